// File: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define EMICB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define EMICB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/emicb_pkg.sv
// ---------------------------------------------------------------------------
// emicb_pkg
// Shared widths, constants, item types and the quarter-wave sine table of
// the environment map importance builder.
// ---------------------------------------------------------------------------
package emicb_pkg;

	localparam int MAX_WIDTH          = 4096;
	localparam int MAX_HEIGHT         = 2048;
	localparam int SINE_TABLE_ENTRIES = 256;

	// field widths
	localparam int WCFG_W   = 13;
	localparam int HCFG_W   = 12;
	localparam int PHASE_W  = 32;
	localparam int CHAN_W   = 32;
	localparam int COL_W    = 12;
	localparam int ROW_W    = 11;
	localparam int SUM_W    = 63;
	localparam int LUM_W    = 32;
	localparam int SINE_W   = 17;
	localparam int WEIGHT_W = LUM_W + SINE_W;
	localparam int PROD_W   = CHAN_W + 16;

	// sine table addressing
	localparam int SINE_LOG = $clog2(SINE_TABLE_ENTRIES);
	localparam int IDX_W    = SINE_LOG + 1;
	localparam int FRAC_W   = 30 - SINE_LOG;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_HALF_TURN    = 2'd2;

	// configuration reset values
	localparam logic [WCFG_W-1:0]  WIDTH_RESET     = 13'd1024;
	localparam logic [HCFG_W-1:0]  HEIGHT_RESET    = 12'd512;
	localparam logic [PHASE_W-1:0] HALF_TURN_RESET = 32'd4194304;

	// rec.709 luminance weights in q16, they sum to exactly one
	localparam logic [15:0] LUM_R = 16'd13933;
	localparam logic [15:0] LUM_G = 16'd46871;
	localparam logic [15:0] LUM_B = 16'd4732;
	localparam logic [PROD_W-1:0] LUM_ROUND = PROD_W'(32768);

	localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [SUM_W-1:0]  TOTAL_ONE = SUM_W'(64'd1 << 32);
	localparam logic [SINE_W-1:0] SINE_FLOOR = SINE_W'(1);
	localparam logic [30:0]       QUARTER_TURN = 31'h4000_0000;

	localparam logic [63:0] ONE_Q30     = 64'h4000_0000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_TABLE_ENTRIES];

	// one pixel after classification
	typedef struct packed {
		logic [LUM_W-1:0] lum;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             rend;
		logic             fend;
	} emicb_item_t;

	// request to the sine unit
	typedef struct packed {
		logic               start;
		logic [PHASE_W-1:0] phase;
	} emicb_sine_req_t;

	// sin(k*pi/(2N)) in q16 through an odd taylor series in q30
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
			x  = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_ENTRIES / 2)) / SINE_TABLE_ENTRIES;
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
			s  = (x * t) >> 30;
			s  = (s + 64'd8192) >> 14;
			if (s > 64'd65536) begin
				s = 64'd65536;
			end
			tab[k] = s[SINE_W-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: design/emicb_front.sv
// ---------------------------------------------------------------------------
// emicb_front
// Takes pixels, forms luminance and tags each item with its column, row and
// row/frame end flags. Accepts only while the queue has room for it.
// ---------------------------------------------------------------------------
module emicb_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic [emicb_pkg::WCFG_W-1:0]        width_eff,
	input  logic [emicb_pkg::HCFG_W-1:0]        height_eff,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [emicb_pkg::CHAN_W-1:0]        red,
	input  logic [emicb_pkg::CHAN_W-1:0]        green,
	input  logic [emicb_pkg::CHAN_W-1:0]        blue,
	input  logic [emicb_pkg::CNT_W-1:0]         q_count,
	output logic                                push,
	output emicb_pkg::emicb_item_t              push_item
);

	logic [emicb_pkg::COL_W-1:0]  col_q;
	logic [emicb_pkg::ROW_W-1:0]  row_q;
	logic                         valid_s1;
	logic [emicb_pkg::PROD_W-1:0] prod_r_s1;
	logic [emicb_pkg::PROD_W-1:0] prod_g_s1;
	logic [emicb_pkg::PROD_W-1:0] prod_b_s1;
	logic [emicb_pkg::COL_W-1:0]  col_s1;
	logic [emicb_pkg::ROW_W-1:0]  row_s1;
	logic                         rend_s1;
	logic                         fend_s1;
	logic [emicb_pkg::CNT_W:0]    used;
	logic                         accept;
	logic                         rend;
	logic                         fend;
	logic [emicb_pkg::PROD_W-1:0] lum_sum;

	// queue slots already spoken for, including the item in flight
	assign used     = {1'b0, q_count} + {{emicb_pkg::CNT_W{1'b0}}, valid_s1};
	assign in_ready = used < (emicb_pkg::CNT_W + 1)'(emicb_pkg::QDEPTH);
	assign accept   = in_valid && in_ready;

	assign rend = ({1'b0, col_q} + 13'd1) >= width_eff;
	assign fend = rend && (({1'b0, row_q} + 12'd1) >= height_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (restart) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (fend) begin
					col_q <= '0;
					row_q <= '0;
				end else if (rend) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_r_s1 <= emicb_pkg::PROD_W'(red)   * emicb_pkg::PROD_W'(emicb_pkg::LUM_R);
			prod_g_s1 <= emicb_pkg::PROD_W'(green) * emicb_pkg::PROD_W'(emicb_pkg::LUM_G);
			prod_b_s1 <= emicb_pkg::PROD_W'(blue)  * emicb_pkg::PROD_W'(emicb_pkg::LUM_B);
			col_s1    <= col_q;
			row_s1    <= row_q;
			rend_s1   <= rend;
			fend_s1   <= fend;
		end
	end

	// the weighted sum stays below 2^48, so the top 32 bits are the luminance
	assign lum_sum = prod_r_s1 + prod_g_s1 + prod_b_s1 + emicb_pkg::LUM_ROUND;

	assign push           = valid_s1;
	assign push_item.lum  = lum_sum[emicb_pkg::PROD_W-1:16];
	assign push_item.col  = col_s1;
	assign push_item.row  = row_s1;
	assign push_item.rend = rend_s1;
	assign push_item.fend = fend_s1;

endmodule

// File: design/emicb_fifo.sv
// ---------------------------------------------------------------------------
// emicb_fifo
// Short item queue between the front and back halves.
// ---------------------------------------------------------------------------
module emicb_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  emicb_pkg::emicb_item_t       push_item,
	input  logic                         pop,
	output emicb_pkg::emicb_item_t       head_item,
	output logic                         empty,
	output logic [emicb_pkg::CNT_W-1:0]  count
);

	emicb_pkg::emicb_item_t      slot_q [emicb_pkg::QDEPTH];
	logic [emicb_pkg::PTR_W-1:0] wr_ptr_q;
	logic [emicb_pkg::PTR_W-1:0] rd_ptr_q;
	logic [emicb_pkg::CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign head_item = slot_q[rd_ptr_q];
	assign empty     = count_q == '0;
	assign count     = count_q;

endmodule

// File: design/emicb_sine.sv
// ---------------------------------------------------------------------------
// emicb_sine
// Two-stage sine of a row phase: table lookup, then linear interpolation.
// Negative half-turn and a zero result give the floor value of one lsb.
// ---------------------------------------------------------------------------
module emicb_sine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  emicb_pkg::emicb_sine_req_t    req,
	output logic                          busy,
	output logic [emicb_pkg::SINE_W-1:0]  row_sine
);

	logic                          valid_s1;
	logic                          neg_s1;
	logic [emicb_pkg::SINE_W-1:0]  a_s1;
	logic [emicb_pkg::SINE_W-1:0]  d_s1;
	logic [emicb_pkg::FRAC_W-1:0]  frac_s1;
	logic [emicb_pkg::SINE_W-1:0]  row_sine_q;

	logic [1:0]                    quad;
	logic [30:0]                   pos;
	logic [emicb_pkg::IDX_W-1:0]   idx;
	logic [emicb_pkg::IDX_W-1:0]   idx_b;
	logic                          at_top;
	logic [emicb_pkg::SINE_W-1:0]  tab_a;
	logic [emicb_pkg::SINE_W-1:0]  tab_b;
	logic [emicb_pkg::SINE_W+emicb_pkg::FRAC_W-1:0] interp;
	logic [emicb_pkg::SINE_W:0]    value;

	assign quad   = req.phase[31:30];
	// second quadrant is the first one mirrored
	assign pos    = quad[0] ? (emicb_pkg::QUARTER_TURN - {1'b0, req.phase[29:0]})
	                        : {1'b0, req.phase[29:0]};
	assign idx    = pos[30:emicb_pkg::FRAC_W];
	assign at_top = idx[emicb_pkg::IDX_W-1];
	assign idx_b  = at_top ? idx : idx + 1'b1;
	assign tab_a  = emicb_pkg::SINE_TAB[idx];
	assign tab_b  = emicb_pkg::SINE_TAB[idx_b];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_s1  <= quad[1];
			a_s1    <= tab_a;
			d_s1    <= (tab_b >= tab_a) ? tab_b - tab_a : '0;
			frac_s1 <= pos[emicb_pkg::FRAC_W-1:0];
		end
	end

	assign interp = (emicb_pkg::SINE_W + emicb_pkg::FRAC_W)'(d_s1)
	                * (emicb_pkg::SINE_W + emicb_pkg::FRAC_W)'(frac_s1)
	                + (emicb_pkg::SINE_W + emicb_pkg::FRAC_W)'(1 << (emicb_pkg::FRAC_W - 1));
	assign value  = {1'b0, a_s1}
	                + (emicb_pkg::SINE_W + 1)'(interp >> emicb_pkg::FRAC_W);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (neg_s1 || value == '0) begin
				row_sine_q <= emicb_pkg::SINE_FLOOR;
			end else begin
				row_sine_q <= value[emicb_pkg::SINE_W-1:0];
			end
		end
	end

	assign busy     = valid_s1;
	assign row_sine = row_sine_q;

endmodule

// File: design/emicb_back.sv
// ---------------------------------------------------------------------------
// emicb_back
// Weights queued items by the row sine, keeps the row and marginal sums and
// drives the result register. Row ends start the sine for the next row phase.
// ---------------------------------------------------------------------------
module emicb_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            restart,
	input  logic [emicb_pkg::PHASE_W-1:0]   half_turn,
	input  emicb_pkg::emicb_item_t          head_item,
	input  logic                            q_empty,
	output logic                            pop,
	output emicb_pkg::emicb_sine_req_t      sine_req,
	input  logic                            sine_busy,
	input  logic [emicb_pkg::SINE_W-1:0]    row_sine,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [emicb_pkg::SUM_W-1:0]     row_prefix,
	output logic [emicb_pkg::COL_W-1:0]     column_index,
	output logic [emicb_pkg::ROW_W-1:0]     row_index,
	output logic                            row_end,
	output logic [emicb_pkg::SUM_W-1:0]     rows_prefix,
	output logic                            frame_end,
	output logic [emicb_pkg::SUM_W-1:0]     total_luminance
);

	logic                              kick_q;
	logic [emicb_pkg::PHASE_W-1:0]     row_phase_q;
	logic [emicb_pkg::SUM_W-1:0]       row_sum_q;
	logic [emicb_pkg::SUM_W-1:0]       marginal_q;

	logic                              valid_s1;
	logic [emicb_pkg::WEIGHT_W-1:0]    weight_s1;
	logic [emicb_pkg::COL_W-1:0]       col_s1;
	logic [emicb_pkg::ROW_W-1:0]       row_s1;
	logic                              rend_s1;
	logic                              fend_s1;

	logic                              valid_s2;
	logic [emicb_pkg::SUM_W-1:0]       rsum_s2;
	logic [emicb_pkg::COL_W-1:0]       col_s2;
	logic [emicb_pkg::ROW_W-1:0]       row_s2;
	logic                              rend_s2;
	logic                              fend_s2;

	logic                              out_valid_q;
	logic [emicb_pkg::SUM_W-1:0]       row_prefix_q;
	logic [emicb_pkg::COL_W-1:0]       column_q;
	logic [emicb_pkg::ROW_W-1:0]       row_q;
	logic                              row_end_q;
	logic [emicb_pkg::SUM_W-1:0]       rows_prefix_q;
	logic                              frame_end_q;
	logic [emicb_pkg::SUM_W-1:0]       total_q;

	logic                              adv_out;
	logic                              adv_s2;
	logic [emicb_pkg::PHASE_W-1:0]     phase_start;
	logic [emicb_pkg::PHASE_W-1:0]     phase_next;
	logic [emicb_pkg::SUM_W:0]         rsum_wide;
	logic [emicb_pkg::SUM_W-1:0]       rsum_sat;
	logic [emicb_pkg::SUM_W:0]         msum_wide;
	logic [emicb_pkg::SUM_W-1:0]       msum_sat;

	assign adv_out = valid_s2 && (!out_valid_q || out_ready);
	assign adv_s2  = valid_s1 && (!valid_s2 || adv_out);
	// hold the queue while the sine for the coming row is not settled
	assign pop     = !q_empty && !kick_q && !sine_busy && (!valid_s1 || adv_s2);

	assign phase_start = half_turn >> 1;
	assign phase_next  = head_item.fend ? phase_start : row_phase_q + half_turn;

	always_comb begin
		sine_req.start = 1'b0;
		sine_req.phase = phase_start;
		if (kick_q) begin
			sine_req.start = 1'b1;
		end else if (pop && head_item.rend) begin
			sine_req.start = 1'b1;
			sine_req.phase = phase_next;
		end
	end

	assign rsum_wide = {1'b0, row_sum_q} + (emicb_pkg::SUM_W + 1)'(weight_s1);
	assign rsum_sat  = rsum_wide[emicb_pkg::SUM_W] ? emicb_pkg::SUM_MAX
	                                               : rsum_wide[emicb_pkg::SUM_W-1:0];
	assign msum_wide = {1'b0, marginal_q} + {1'b0, rsum_s2};
	assign msum_sat  = msum_wide[emicb_pkg::SUM_W] ? emicb_pkg::SUM_MAX
	                                               : msum_wide[emicb_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_q      <= 1'b1;
			row_phase_q <= emicb_pkg::HALF_TURN_RESET >> 1;
			row_sum_q   <= '0;
			marginal_q  <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (restart) begin
			kick_q      <= 1'b1;
			row_sum_q   <= '0;
			marginal_q  <= '0;
		end else begin
			kick_q <= 1'b0;
			if (kick_q) begin
				row_phase_q <= phase_start;
			end else if (pop && head_item.rend) begin
				row_phase_q <= phase_next;
			end
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2  <= 1'b1;
				row_sum_q <= rend_s1 ? '0 : rsum_sat;
			end else if (adv_out) begin
				valid_s2 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= 1'b1;
				if (rend_s2) begin
					marginal_q <= fend_s2 ? '0 : msum_sat;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			weight_s1 <= emicb_pkg::WEIGHT_W'(head_item.lum)
			             * emicb_pkg::WEIGHT_W'(row_sine);
			col_s1    <= head_item.col;
			row_s1    <= head_item.row;
			rend_s1   <= head_item.rend;
			fend_s1   <= head_item.fend;
		end
		if (adv_s2) begin
			rsum_s2 <= rsum_sat;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			rend_s2 <= rend_s1;
			fend_s2 <= fend_s1;
		end
		if (adv_out) begin
			row_prefix_q  <= rsum_s2;
			column_q      <= col_s2;
			row_q         <= row_s2;
			row_end_q     <= rend_s2;
			frame_end_q   <= fend_s2;
			rows_prefix_q <= rend_s2 ? msum_sat : '0;
			if (!fend_s2) begin
				total_q <= '0;
			end else if (msum_sat == '0) begin
				total_q <= emicb_pkg::TOTAL_ONE;
			end else begin
				total_q <= msum_sat;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign row_prefix      = row_prefix_q;
	assign column_index    = column_q;
	assign row_index       = row_q;
	assign row_end         = row_end_q;
	assign rows_prefix     = rows_prefix_q;
	assign frame_end       = frame_end_q;
	assign total_luminance = total_q;

endmodule

// File: design/env_map_importance_cdf_builder.sv
// ---------------------------------------------------------------------------
// env_map_importance_cdf_builder
// Streams hdr pixels in raster order and emits, per pixel, the row prefix
// sum of sine-weighted luminance, plus marginal prefix and frame total.
// ---------------------------------------------------------------------------
// path: front register, queue, back stages s1 and s2, then result register
// throughput: one item per cycle within a row unless the output stalls; each
//   row end holds the back end while the two-stage sine unit settles the
//   next row. reset: counters, sums and queue clear, config takes defaults,
//   and the first item waits until the sine of the first row has settled
// a write to width, height or half turn restarts counters, sums and sine
module env_map_importance_cdf_builder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [emicb_pkg::PHASE_W-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [emicb_pkg::CHAN_W-1:0]        red,
	input  logic [emicb_pkg::CHAN_W-1:0]        green,
	input  logic [emicb_pkg::CHAN_W-1:0]        blue,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [emicb_pkg::SUM_W-1:0]         row_prefix,
	output logic [emicb_pkg::COL_W-1:0]         column_index,
	output logic [emicb_pkg::ROW_W-1:0]         row_index,
	output logic                                row_end,
	output logic [emicb_pkg::SUM_W-1:0]         rows_prefix,
	output logic                                frame_end,
	output logic [emicb_pkg::SUM_W-1:0]         total_luminance
);

	logic [emicb_pkg::WCFG_W-1:0]  width_q;
	logic [emicb_pkg::HCFG_W-1:0]  height_q;
	logic [emicb_pkg::PHASE_W-1:0] half_turn_q;
	logic [emicb_pkg::WCFG_W-1:0]  width_eff;
	logic [emicb_pkg::HCFG_W-1:0]  height_eff;
	logic                          cfg_write;
	logic                          restart;

	logic                          push;
	emicb_pkg::emicb_item_t        push_item;
	emicb_pkg::emicb_item_t        head_item;
	logic                          q_empty;
	logic [emicb_pkg::CNT_W-1:0]   q_count;
	logic                          pop;
	emicb_pkg::emicb_sine_req_t    sine_req;
	logic                          sine_busy;
	logic [emicb_pkg::SINE_W-1:0]  row_sine;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_comb begin
		case (cfg_index)
			emicb_pkg::CFG_IMAGE_WIDTH:  restart = cfg_write;
			emicb_pkg::CFG_IMAGE_HEIGHT: restart = cfg_write;
			emicb_pkg::CFG_HALF_TURN:    restart = cfg_write;
			default:                     restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= emicb_pkg::WIDTH_RESET;
			height_q    <= emicb_pkg::HEIGHT_RESET;
			half_turn_q <= emicb_pkg::HALF_TURN_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				emicb_pkg::CFG_IMAGE_WIDTH:  width_q     <= cfg_data[emicb_pkg::WCFG_W-1:0];
				emicb_pkg::CFG_IMAGE_HEIGHT: height_q    <= cfg_data[emicb_pkg::HCFG_W-1:0];
				emicb_pkg::CFG_HALF_TURN:    half_turn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the geometry into one to the maximum
	always_comb begin
		if (width_q == '0) begin
			width_eff = emicb_pkg::WCFG_W'(1);
		end else if (width_q > emicb_pkg::WCFG_W'(emicb_pkg::MAX_WIDTH)) begin
			width_eff = emicb_pkg::WCFG_W'(emicb_pkg::MAX_WIDTH);
		end else begin
			width_eff = width_q;
		end
		if (height_q == '0) begin
			height_eff = emicb_pkg::HCFG_W'(1);
		end else if (height_q > emicb_pkg::HCFG_W'(emicb_pkg::MAX_HEIGHT)) begin
			height_eff = emicb_pkg::HCFG_W'(emicb_pkg::MAX_HEIGHT);
		end else begin
			height_eff = height_q;
		end
	end

	emicb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.q_count    (q_count),
		.push       (push),
		.push_item  (push_item)
	);

	emicb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.empty     (q_empty),
		.count     (q_count)
	);

	emicb_sine u_sine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (sine_req),
		.busy     (sine_busy),
		.row_sine (row_sine)
	);

	emicb_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.restart         (restart),
		.half_turn       (half_turn_q),
		.head_item       (head_item),
		.q_empty         (q_empty),
		.pop             (pop),
		.sine_req        (sine_req),
		.sine_busy       (sine_busy),
		.row_sine        (row_sine),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.row_prefix      (row_prefix),
		.column_index    (column_index),
		.row_index       (row_index),
		.row_end         (row_end),
		.rows_prefix     (rows_prefix),
		.frame_end       (frame_end),
		.total_luminance (total_luminance)
	);

endmodule

// File: design/emicb_checker.sv
// ---------------------------------------------------------------------------
// emicb_checker
// Port-level checks on the result channel of the importance builder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module emicb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [emicb_pkg::SUM_W-1:0]    row_prefix,
	input logic                           row_end,
	input logic [emicb_pkg::SUM_W-1:0]    rows_prefix,
	input logic                           frame_end,
	input logic [emicb_pkg::SUM_W-1:0]    total_luminance
);

	`EMICB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(row_prefix), "result dropped or changed while stalled")
	`EMICB_ASSERT_NOW(a_frame_in_row, out_valid && frame_end, row_end, "frame end without row end")
	`EMICB_ASSERT_NOW(a_mid_row_zero, out_valid && !row_end, rows_prefix == '0 && total_luminance == '0, "marginal or total set mid row")
	`EMICB_ASSERT_NOW(a_total_nonzero, out_valid && frame_end, total_luminance != '0 && total_luminance == rows_prefix || total_luminance == emicb_pkg::TOTAL_ONE, "bad frame total")

endmodule

bind env_map_importance_cdf_builder emicb_checker u_emicb_checker (.*);

// File: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for env_map_importance_cdf_builder. Pixels are driven
// through the valid/ready input while an independent prediction of the
// sine-weighted luminance sums is kept alongside. Every result is compared
// field by field, in order. Register settings are changed between bursts,
// both handshakes idle at random, and a closing bright frame runs back to
// back with full and floored row sines.
// ---------------------------------------------------------------------------

localparam logic [1:0]  CFG_UNUSED    = 2'd3;
localparam bit [63:0]   SUM_SAT       = 64'h7FFF_FFFF_FFFF_FFFF;
localparam bit [63:0]   Q30_ONE       = 64'h4000_0000;
localparam bit [63:0]   Q30_HALF_PI   = 64'd1686629713;
localparam bit [63:0]   LUMA_RED      = 64'd13933;
localparam bit [63:0]   LUMA_GREEN    = 64'd46871;
localparam bit [63:0]   LUMA_BLUE     = 64'd4732;
localparam bit [63:0]   EMPTY_TOTAL   = 64'h1_0000_0000;
localparam int          LUT_N         = emicb_pkg::SINE_TABLE_ENTRIES;
localparam int unsigned HOLD_CYCLES   = 200;
localparam int unsigned TAIL_CYCLES   = 16;
localparam int unsigned RUN_LIMIT     = 2000000;
localparam int unsigned SOAK_WIDTH    = 16;
localparam int unsigned SOAK_HEIGHT   = 4;
localparam int unsigned PHASE_ITEMS   = 65;

typedef struct packed {
	logic [emicb_pkg::SUM_W-1:0] row_prefix;
	logic [emicb_pkg::COL_W-1:0] col;
	logic [emicb_pkg::ROW_W-1:0] row;
	logic                        row_end;
	logic [emicb_pkg::SUM_W-1:0] rows_prefix;
	logic                        frame_end;
	logic [emicb_pkg::SUM_W-1:0] total;
} cdf_entry_t;

class cdf_scoreboard;
	bit [16:0]   sine_lut [0:LUT_N];
	bit [12:0]   width_reg;
	bit [11:0]   height_reg;
	bit [31:0]   turn_reg;
	int unsigned col;
	int unsigned row;
	bit [63:0]   row_acc;
	bit [63:0]   rows_acc;
	bit [31:0]   phase;
	bit [16:0]   sine;
	cdf_entry_t  awaited_entries[$];
	int unsigned errors;

	function new();
		bit [63:0]   x;
		bit [63:0]   x2;
		bit [63:0]   t;
		bit [63:0]   s;
		bit [63:0]   divs [6];
		divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		// quarter wave, odd series in q30 rounded to q16
		for (int k = 0; k <= LUT_N; k++) begin
			x  = (64'(k) * Q30_HALF_PI + 64'(LUT_N / 2)) / 64'(LUT_N);
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			for (int i = 0; i < 6; i++) begin
				t = Q30_ONE - ((x2 * t) >> 30) / divs[i];
			end
			s = (x * t) >> 30;
			s = (s + 64'd8192) >> 14;
			if (s > 64'd65536) begin
				s = 64'd65536;
			end
			sine_lut[k] = s[16:0];
		end
		width_reg  = 13'd1024;
		height_reg = 12'd512;
		turn_reg   = 32'd4194304;
		errors     = 0;
		restart();
	endfunction

	function bit [16:0] phase_sine(bit [31:0] ph);
		bit [63:0] p;
		bit [63:0] pos;
		bit [63:0] idx;
		bit [63:0] frac;
		bit [63:0] v;
		bit [63:0] lo;
		bit [63:0] hi;
		bit [63:0] d;
		// lower half turn is negative sine, floored
		if (ph[31]) begin
			return 17'd1;
		end
		p = 64'(ph[29:0]);
		if (ph[30]) begin
			p = Q30_ONE - p;
		end
		pos  = p * 64'(LUT_N);
		idx  = pos >> 30;
		frac = pos & 64'h3FFF_FFFF;
		if (idx >= 64'(LUT_N)) begin
			v = 64'(sine_lut[LUT_N]);
		end else begin
			lo = 64'(sine_lut[idx]);
			hi = 64'(sine_lut[idx + 1]);
			d  = (hi >= lo) ? hi - lo : 64'd0;
			v  = lo + ((d * frac + 64'h2000_0000) >> 30);
		end
		if (v == 0) begin
			v = 64'd1;
		end
		return v[16:0];
	endfunction

	function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
		bit [63:0] s;
		s = a + b;
		return (s > SUM_SAT) ? SUM_SAT : s;
	endfunction

	function void restart();
		col      = 0;
		row      = 0;
		row_acc  = 0;
		rows_acc = 0;
		phase    = turn_reg >> 1;
		sine     = phase_sine(phase);
	endfunction

	function void write_reg(logic [1:0] idx, bit [31:0] data);
		case (idx)
			emicb_pkg::CFG_IMAGE_WIDTH: begin
				width_reg = data[12:0];
			end
			emicb_pkg::CFG_IMAGE_HEIGHT: begin
				height_reg = data[11:0];
			end
			emicb_pkg::CFG_HALF_TURN: begin
				turn_reg = data;
			end
			default: begin
				return;
			end
		endcase
		restart();
	endfunction

	function void note_pixel(bit [31:0] r, bit [31:0] g, bit [31:0] b);
		int unsigned w;
		int unsigned h;
		bit [63:0]   lum;
		bit [63:0]   weight;
		bit          rend;
		bit          fend;
		cdf_entry_t  e;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > emicb_pkg::MAX_WIDTH) w = emicb_pkg::MAX_WIDTH;
		h = height_reg;
		if (h < 1) h = 1;
		if (h > emicb_pkg::MAX_HEIGHT) h = emicb_pkg::MAX_HEIGHT;
		lum = (LUMA_RED * 64'(r) + LUMA_GREEN * 64'(g) + LUMA_BLUE * 64'(b)
			+ 64'd32768) >> 16;
		weight  = lum * 64'(sine);
		row_acc = sat_add(row_acc, weight);
		rend    = (col + 1 >= w);
		fend    = rend && (row + 1 >= h);
		e             = '0;
		e.row_prefix  = row_acc[62:0];
		e.col         = col[11:0];
		e.row         = row[10:0];
		e.row_end     = rend;
		e.frame_end   = fend;
		if (rend) begin
			rows_acc      = sat_add(rows_acc, row_acc);
			e.rows_prefix = rows_acc[62:0];
			if (fend) begin
				e.total = (rows_acc == 0) ? EMPTY_TOTAL[62:0] : rows_acc[62:0];
				restart();
			end else begin
				col     = 0;
				row_acc = 0;
				row++;
				phase  += turn_reg;
				sine    = phase_sine(phase);
			end
		end else begin
			col++;
		end
		awaited_entries.push_back(e);
	endfunction

	function void compare(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("tb: %0t mismatch %s expected %0h actual %0h", $time, what,
				want, got);
		end
	endfunction

	function void check_result(cdf_entry_t got);
		cdf_entry_t want;
		if (awaited_entries.size() == 0) begin
			errors++;
			$display("tb: %0t unexpected item expected none actual row_prefix %0h",
				$time, got.row_prefix);
			return;
		end
		want = awaited_entries.pop_front();
		compare("row_prefix", want.row_prefix, got.row_prefix);
		compare("column_index", want.col, got.col);
		compare("row_index", want.row, got.row);
		compare("row_end", want.row_end, got.row_end);
		compare("rows_prefix", want.rows_prefix, got.rows_prefix);
		compare("frame_end", want.frame_end, got.frame_end);
		compare("total_luminance", want.total, got.total);
	endfunction

	function int unsigned pending();
		return awaited_entries.size();
	endfunction
endclass

module tb;
	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [1:0]                        cfg_index;
	logic [emicb_pkg::PHASE_W-1:0]     cfg_data;
	logic                              in_valid;
	logic                              in_ready;
	logic [emicb_pkg::CHAN_W-1:0]      red;
	logic [emicb_pkg::CHAN_W-1:0]      green;
	logic [emicb_pkg::CHAN_W-1:0]      blue;
	logic                              out_valid;
	logic                              out_ready;
	logic [emicb_pkg::SUM_W-1:0]       row_prefix;
	logic [emicb_pkg::COL_W-1:0]       column_index;
	logic [emicb_pkg::ROW_W-1:0]       row_index;
	logic                              row_end;
	logic [emicb_pkg::SUM_W-1:0]       rows_prefix;
	logic                              frame_end;
	logic [emicb_pkg::SUM_W-1:0]       total_luminance;

	cdf_scoreboard sb;
	bit            steady;
	bit            hold_off;
	int unsigned   cycle_count;

	env_map_importance_cdf_builder uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.row_prefix      (row_prefix),
		.column_index    (column_index),
		.row_index       (row_index),
		.row_end         (row_end),
		.rows_prefix     (rows_prefix),
		.frame_end       (frame_end),
		.total_luminance (total_luminance)
	);

	always #6 clk = ~clk;

	function automatic bit [31:0] radiance();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 65535);
			3: return 32'h0001_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_pixel(input bit [31:0] r, input bit [31:0] g, input bit [31:0] b);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_pixel(r, g, b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input bit [31:0] data, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, data);
		if (last) begin
			cfg_valid <= 1'b0;
		end
	endtask

	task automatic setup(input bit [31:0] wv, input bit [31:0] hv, input bit [31:0] tv,
			input bit junk);
		drain();
		cfg_write(emicb_pkg::CFG_IMAGE_WIDTH, wv, 1'b0);
		cfg_write(emicb_pkg::CFG_IMAGE_HEIGHT, hv, 1'b0);
		cfg_write(emicb_pkg::CFG_HALF_TURN, tv, !junk);
		if (junk) begin
			cfg_write(CFG_UNUSED, $urandom, 1'b1);
		end
	endtask

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: FAIL");
		$finish;
	end

	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			sb.check_result({row_prefix, column_index, row_index, row_end, rows_prefix,
				frame_end, total_luminance});
		end
	end

	initial begin : stimulus
		int unsigned w;
		int unsigned h;
		bit [31:0]   turn;
		sb        = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = emicb_pkg::CFG_IMAGE_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		red       = '0;
		green     = '0;
		blue      = '0;
		out_ready = 1'b0;
		steady    = 1'b0;
		hold_off  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// settings out of reset, channel extremes
		send_pixel(32'h0, 32'h0, 32'h0);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF, 32'h0, 32'h0);
		send_pixel(32'h0, 32'hFFFF_FFFF, 32'h0);
		send_pixel(32'h0, 32'h0, 32'hFFFF_FFFF);
		send_pixel(32'h0001_0000, 32'h0000_8000, 32'h0000_0001);
		// unknown register index leaves the frame running
		drain();
		cfg_write(CFG_UNUSED, 32'hFFFF_FFFF, 1'b1);
		send_pixel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

		// zero width and height clamp to one, zero phase floors the sine
		setup(32'h0000_2000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		send_pixel(32'h0, 32'h0, 32'h0);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'h0, 32'h0, 32'h0000_0001);

		// half-turn rows: phase lands in the negative half every other row
		setup(32'd3, 32'd2, 32'h8000_0000, 1'b0);
		repeat (6) send_pixel(radiance(), radiance(), radiance());

		// oversized width and height clamp to the maxima
		setup(32'h0000_1FFF, 32'h0000_0FFF, 32'h0010_0000, 1'b0);
		repeat (4) send_pixel(radiance(), radiance(), radiance());

		for (int ph = 0; ph < 8; ph++) begin
			w = $urandom_range(0, 12);
			h = $urandom_range(0, 6);
			case ($urandom_range(0, 3))
				0: turn = 32'h0010_0000;
				1: turn = 32'h8000_0000;
				2: turn = 32'h8000_0000 / ((h == 0) ? 1 : h);
				default: turn = $urandom;
			endcase
			setup(($urandom & 32'hFFFF_E000) | w, ($urandom & 32'hFFFF_F000) | h, turn,
				$urandom_range(0, 2) == 0);
			steady = (ph == 3);
			// sink holds off while the source keeps pushing
			if (ph == 2) begin
				hold_off = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 5 && i == 40) begin
					drain();
				end
				send_pixel(radiance(), radiance(), radiance());
			end
		end

		// bright frame back to back, full sine and floored sine on alternate rows
		setup(SOAK_WIDTH, SOAK_HEIGHT, 32'h8000_0000, 1'b0);
		steady = 1'b1;
		repeat (SOAK_WIDTH * SOAK_HEIGHT) begin
			send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		end
		steady = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
